// ----- sv/sbphr_pkg.sv -----
// Shared types, constants and the bar gradient table for the spectrum bar renderer.
// No dependencies; imported by every module of the block.
package sbphr_pkg;

	localparam int NUM_BANDS    = 128;
	localparam int PANEL_HEIGHT = 32;

	localparam int BAND_W   = 7;
	localparam int LEVEL_W  = 10;
	localparam int ROW_W    = 6;
	localparam int COLOR_W  = 16;
	localparam int STEP_W   = 8;
	localparam int SCALE_SH = 8;

	localparam int BAND_AW = $clog2(NUM_BANDS);
	localparam int Y_AW    = $clog2(PANEL_HEIGHT);
	localparam int PROD_W  = LEVEL_W + ROW_W;
	localparam int BARR_W  = PROD_W - SCALE_SH;

	localparam logic [COLOR_W-1:0] DOT_COLOR      = 16'hFFFF;
	localparam logic [STEP_W-1:0]  DECAY_STEP_RST = 8'd13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_BAR,
		ST_END
	} state_t;

	typedef struct packed {
		logic accept;
		logic upd;
		logic emit_bar;
		logic emit_end;
	} dp_cmd_t;

	typedef struct packed {
		logic bar_nz;
		logic band_ok;
		logic dot_ok;
		logic y_last;
		logic slot_free;
	} dp_stat_t;

	typedef logic [COLOR_W-1:0] color_tbl_t [PANEL_HEIGHT];

	// cyan -> yellow -> red gradient, RGB565, indexed by bar row (0 = bottom)
	function automatic color_tbl_t build_color_tbl();
		color_tbl_t t;
		int y;
		int r;
		int g;
		int b;
		for (y = 0; y < PANEL_HEIGHT; y++) begin
			if (5 * y < 2 * PANEL_HEIGHT) begin
				r = 0;
				g = (500 * y) / PANEL_HEIGHT;
				b = 255;
			end else if (4 * y < 3 * PANEL_HEIGHT) begin
				r = (255 * (20 * y - 8 * PANEL_HEIGHT)) / (7 * PANEL_HEIGHT);
				g = 255;
				b = 0;
			end else begin
				r = 255;
				g = (200 * (PANEL_HEIGHT - y)) / PANEL_HEIGHT;
				b = (200 * (4 * y - 3 * PANEL_HEIGHT)) / PANEL_HEIGHT;
			end
			t[y] = COLOR_W'((((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hFF) >> 3))
				& 'hFFFF);
		end
		return t;
	endfunction

	localparam color_tbl_t BAR_COLOR_TBL = build_color_tbl();

endpackage

// ----- sv/spectrum_bar_peak_hold_renderer_core.sv -----
// Spectrum bar renderer with per-band peak hold: top level.
// Depends on sbphr_pkg, sbphr_ctrl and sbphr_dp.
// Sequence: a request is accepted in IDLE, its peak is updated in UPD, and its
//   results then go into the output register. A new request is taken only after all
//   results of the previous one (bar rows plus peak dot, or 1 unlit result) are in,
//   as the single output register walks the rows; sink stalls hold that walk.
// Reset: arst_n clears state, output valid, the peak store valid bits (peaks read as 0)
//   and sets decay_step to 13.
module spectrum_bar_peak_hold_renderer_core import sbphr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BAND_W-1:0]   band_index,
	input  logic [LEVEL_W-1:0]  level,
	input  logic                decay_now,
	// decay_step register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [STEP_W-1:0]   cfg_data,
	// pixel channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [BAND_W-1:0]   band_out,
	output logic [ROW_W-1:0]    screen_row,
	output logic [COLOR_W-1:0]  pixel_color,
	output logic                is_peak,
	output logic                lit,
	output logic                last
);

	// Flow per request:
	//   IDLE  take request, compute clipped bar height, read the band's held peak
	//   UPD   rise-to-level or decay the peak, write it back
	//   BAR   one pixel per unstalled cycle, bottom row first, constant gradient table
	//   END   white peak dot if the peak sits on the panel, otherwise the unlit result
	// Output register keeps the last pixel while the sink stalls.

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sbphr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbphr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.band_index  (band_index),
		.level       (level),
		.decay_now   (decay_now),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.band_out    (band_out),
		.screen_row  (screen_row),
		.pixel_color (pixel_color),
		.is_peak     (is_peak),
		.lit         (lit),
		.last        (last)
	);

endmodule

// ----- sv/sbphr_ctrl.sv -----
// Sequencer for the spectrum bar renderer: accept, peak update, bar rows, final result.
// Depends on sbphr_pkg (state_t, dp_cmd_t, dp_stat_t).
module sbphr_ctrl import sbphr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = (stat.band_ok && stat.bar_nz) ? ST_BAR : ST_END;
			end
			ST_BAR: begin
				if (stat.slot_free) begin
					cmd.emit_bar = 1'b1;
					if (stat.y_last) begin
						state_d = stat.dot_ok ? ST_END : ST_IDLE;
					end
				end
			end
			ST_END: begin
				if (stat.slot_free) begin
					cmd.emit_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/sbphr_dp.sv -----
// Datapath of the spectrum bar renderer: peak store, bar height, row counter, output register.
// Depends on sbphr_pkg (constants, gradient table, command and status structs).
module sbphr_dp import sbphr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [BAND_W-1:0]   band_index,
	input  logic [LEVEL_W-1:0]  level,
	input  logic                decay_now,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [STEP_W-1:0]   cfg_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [BAND_W-1:0]   band_out,
	output logic [ROW_W-1:0]    screen_row,
	output logic [COLOR_W-1:0]  pixel_color,
	output logic                is_peak,
	output logic                lit,
	output logic                last
);

	logic [STEP_W-1:0]  decay_step_q;
	logic [BAND_W-1:0]  band_q;
	logic [LEVEL_W-1:0] level_q;
	logic               decay_q;
	logic               band_ok_q;
	logic [ROW_W-1:0]   bar_q;
	logic [Y_AW-1:0]    y_q;
	logic [LEVEL_W-1:0] pk_q;

	logic [LEVEL_W-1:0] peak_mem [NUM_BANDS];
	logic [LEVEL_W-1:0] rd_q;
	logic [NUM_BANDS-1:0] vld_q;
	logic               vld_rd_q;

	logic               out_valid_q;
	logic [BAND_W-1:0]  band_out_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLOR_W-1:0] color_q;
	logic               is_peak_q;
	logic               lit_q;
	logic               last_q;

	logic [PROD_W-1:0]  lvl_prod;
	logic [BARR_W-1:0]  bar_raw;
	logic [ROW_W-1:0]   bar_clip;
	logic               band_ok;
	logic [LEVEL_W-1:0] pk_cur;
	logic [LEVEL_W-1:0] pk_new;
	logic [PROD_W-1:0]  pk_prod;
	logic [BARR_W-1:0]  dot_raw;
	logic               dot_ok;
	logic [ROW_W-1:0]   dot_row;
	logic               y_last;
	logic               slot_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_step_q <= DECAY_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			decay_step_q <= cfg_data;
		end
	end

	// bar height, clipped to the panel
	assign lvl_prod = PROD_W'(level) * PROD_W'(PANEL_HEIGHT);
	assign bar_raw  = lvl_prod[PROD_W-1:SCALE_SH];
	assign bar_clip = (bar_raw > BARR_W'(PANEL_HEIGHT)) ? ROW_W'(PANEL_HEIGHT)
		: bar_raw[ROW_W-1:0];
	assign band_ok  = (BAND_W+1)'(band_index) < (BAND_W+1)'(NUM_BANDS);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			band_q    <= band_index;
			level_q   <= level;
			decay_q   <= decay_now;
			band_ok_q <= band_ok;
			bar_q     <= bar_clip;
		end
	end

	// peak store: one read port at accept, one write port at update
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= peak_mem[band_index[BAND_AW-1:0]];
		end
		if (cmd.upd && band_ok_q) begin
			peak_mem[band_q[BAND_AW-1:0]] <= pk_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				vld_rd_q <= vld_q[band_index[BAND_AW-1:0]];
			end
			if (cmd.upd && band_ok_q) begin
				vld_q[band_q[BAND_AW-1:0]] <= 1'b1;
			end
		end
	end

	assign pk_cur = vld_rd_q ? rd_q : '0;

	always_comb begin
		if (level_q > pk_cur) begin
			pk_new = level_q;
		end else if (decay_q) begin
			pk_new = (pk_cur > LEVEL_W'(decay_step_q)) ? pk_cur - LEVEL_W'(decay_step_q) : '0;
		end else begin
			pk_new = pk_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			pk_q <= pk_new;
		end
	end

	// peak dot position from the updated peak
	assign pk_prod = PROD_W'(pk_q) * PROD_W'(PANEL_HEIGHT);
	assign dot_raw = pk_prod[PROD_W-1:SCALE_SH];
	assign dot_ok  = band_ok_q && (dot_raw < BARR_W'(PANEL_HEIGHT));
	assign dot_row = ROW_W'(PANEL_HEIGHT - 1) - dot_raw[ROW_W-1:0];

	// bar row counter, 0 = bottom
	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			y_q <= '0;
		end else if (cmd.emit_bar) begin
			y_q <= y_q + Y_AW'(1);
		end
	end

	assign y_last    = (ROW_W'(y_q) + ROW_W'(1)) == bar_q;
	assign slot_free = !out_valid_q || !out_stall;

	assign stat.bar_nz    = (bar_q != '0);
	assign stat.band_ok   = band_ok_q;
	assign stat.dot_ok    = dot_ok;
	assign stat.y_last    = y_last;
	assign stat.slot_free = slot_free;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_bar || cmd.emit_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_bar) begin
			band_out_q <= band_q;
			row_q      <= ROW_W'(PANEL_HEIGHT - 1) - ROW_W'(y_q);
			color_q    <= BAR_COLOR_TBL[y_q];
			is_peak_q  <= 1'b0;
			lit_q      <= 1'b1;
			last_q     <= y_last && !dot_ok;
		end else if (cmd.emit_end) begin
			band_out_q <= band_q;
			last_q     <= 1'b1;
			if (dot_ok) begin
				row_q     <= dot_row;
				color_q   <= DOT_COLOR;
				is_peak_q <= 1'b1;
				lit_q     <= 1'b1;
			end else begin
				row_q     <= '0;
				color_q   <= '0;
				is_peak_q <= 1'b0;
				lit_q     <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign band_out    = band_out_q;
	assign screen_row  = row_q;
	assign pixel_color = color_q;
	assign is_peak     = is_peak_q;
	assign lit         = lit_q;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_peak_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && is_peak_q |-> last_q)
		else $error("peak dot not flagged last");
	a_unlit_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !lit_q |-> last_q && !is_peak_q && (color_q == '0) && (row_q == '0))
		else $error("unlit result not blank");
	a_upd_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> $past(cmd.accept))
		else $error("peak update without accepted request");
	a_bar_needs_height: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_bar |-> (bar_q != '0) && band_ok_q)
		else $error("bar row emitted for empty bar");
`endif

endmodule

// ----- test/spectrum_bar_peak_hold_renderer_core_tb.sv -----
// Self-checking bench for spectrum_bar_peak_hold_renderer_core: bar pixels, peak dots and blank results.
// Needs sbphr_pkg and the core RTL. A cycle-free predictor of the per-band peak store
// checks every pixel, with directed rows first and then random band requests.
module spectrum_bar_peak_hold_renderer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbphr_pkg::*;

	localparam int SETTLE     = 6;     // quiet cycles after the last pixel before a register write
	localparam int LONG_HOLD  = 400;   // output back-pressure stretch that fills the block
	localparam int IDLE_LIMIT = 4000;  // cycles with no handshake at all before giving up
	localparam int MAX_SHOWN  = 10;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic [ROW_W-1:0]   row;
		logic [COLOR_W-1:0] color;
		logic               peak;
		logic               lit;
		logic               last;
	} pixel_t;

	typedef struct {
		logic [BAND_W-1:0]  band;
		logic [LEVEL_W-1:0] lvl;
		logic               decay;
		bit                 typed;
		pixel_t             want;
	} band_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BAND_W-1:0] band_index = '0;
	logic [LEVEL_W-1:0] level = '0;
	logic decay_now = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [STEP_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BAND_W-1:0] band_out;
	logic [ROW_W-1:0] screen_row;
	logic [COLOR_W-1:0] pixel_color;
	logic is_peak;
	logic lit;
	logic last;

	spectrum_bar_peak_hold_renderer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.band_index(band_index),
		.level(level),
		.decay_now(decay_now),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.band_out(band_out),
		.screen_row(screen_row),
		.pixel_color(pixel_color),
		.is_peak(is_peak),
		.lit(lit),
		.last(last)
	);

	// predictor state: held peak per band and the current decay step
	logic [LEVEL_W-1:0] peak_hold [NUM_BANDS];
	logic [STEP_W-1:0]  decay_amt = DECAY_STEP_RST;
	pixel_t             pending_pixels [$];

	bit in_idle = 1'b1;
	bit out_idle = 1'b1;
	bit hold_req = 1'b0;
	int errors = 0;
	int requests_sent = 0;
	int pixels_seen = 0;
	int dots_seen = 0;
	int blanks_seen = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// bar gradient: cyan at the bottom, yellow in the middle, red at the top
	function automatic logic [COLOR_W-1:0] gradient565(input int y);
		int r;
		int g;
		int b;
		if (5 * y < 2 * PANEL_HEIGHT) begin
			r = 0;
			g = (500 * y) / PANEL_HEIGHT;
			b = 255;
		end else if (4 * y < 3 * PANEL_HEIGHT) begin
			r = (255 * (20 * y - 8 * PANEL_HEIGHT)) / (7 * PANEL_HEIGHT);
			g = 255;
			b = 0;
		end else begin
			r = 255;
			g = (200 * (PANEL_HEIGHT - y)) / PANEL_HEIGHT;
			b = (200 * (4 * y - 3 * PANEL_HEIGHT)) / PANEL_HEIGHT;
		end
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Updates the held peak of the band and, if keep is set, queues the pixels it draws.
	function automatic void render_band(input logic [BAND_W-1:0] b,
			input logic [LEVEL_W-1:0] l, input logic dn, input bit keep);
		int bar;
		int pk;
		int dot_d;
		int total;
		pixel_t px;
		bar = (int'(l) * PANEL_HEIGHT) >> SCALE_SH;
		if (bar > PANEL_HEIGHT)
			bar = PANEL_HEIGHT;
		pk = int'(peak_hold[b]);
		if (int'(l) > pk)
			pk = int'(l);
		else if (dn)
			pk = (pk > int'(decay_amt)) ? pk - int'(decay_amt) : 0;
		peak_hold[b] = LEVEL_W'(pk);
		dot_d = (pk * PANEL_HEIGHT) >> SCALE_SH;
		total = bar + ((dot_d < PANEL_HEIGHT) ? 1 : 0);
		if (!keep)
			return;
		if (total == 0) begin
			// nothing on the panel: one blank result
			px = '0;
			px.band = b;
			px.last = 1'b1;
			pending_pixels.push_back(px);
			return;
		end
		for (int i = 0; i < total; i++) begin
			px.band = b;
			px.lit = 1'b1;
			px.last = (i == total - 1);
			if (i < bar) begin
				px.row = ROW_W'(PANEL_HEIGHT - 1 - i);
				px.color = gradient565(i);
				px.peak = 1'b0;
			end else begin
				px.row = ROW_W'(PANEL_HEIGHT - 1 - dot_d);
				px.color = DOT_COLOR;
				px.peak = 1'b1;
			end
			pending_pixels.push_back(px);
		end
	endfunction

	task automatic note_mismatch(input string what, input pixel_t want, input pixel_t got);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%t %s: want band %0d row %0d color %h peak %b lit %b last %b, got band %0d row %0d color %h peak %b lit %b last %b",
				$realtime, what, want.band, want.row, want.color, want.peak, want.lit, want.last,
				got.band, got.row, got.color, got.peak, got.lit, got.last);
	endtask

	// pixel checker
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{band_out, screen_row, pixel_color, is_peak, lit, last};
			pixels_seen++;
			if (is_peak)
				dots_seen++;
			if (!lit)
				blanks_seen++;
			if (pending_pixels.size() == 0)
				note_mismatch("pixel with no request pending", '0, got);
			else if (got !== pending_pixels[0])
				note_mismatch("pixel mismatch", pending_pixels[0], got);
			if (pending_pixels.size() != 0)
				void'(pending_pixels.pop_front());
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// pixel sink: random back-pressure bursts, or one long hold when asked
	initial begin : pixel_sink
		int burst;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (out_idle && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one band request and updates the predictor at the accepting edge.
	// Valid stays high across back-to-back requests.
	task automatic offer_band(input logic [BAND_W-1:0] b, input logic [LEVEL_W-1:0] l,
			input logic dn, input bit typed, input pixel_t want);
		int gap;
		if (in_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		band_index <= b;
		level <= l;
		decay_now <= dn;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		requests_sent++;
		if (typed) begin
			render_band(b, l, dn, 1'b0);
			pending_pixels.push_back(want);
		end else begin
			render_band(b, l, dn, 1'b1);
		end
	endtask

	task automatic wait_all_pixels();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_decay_step(input logic [STEP_W-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		decay_amt = v;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Random requests: half of them hit a few bands so peaks build and decay;
	// levels cluster at low values, full range, and around the held peak.
	task automatic random_bands(input int count, input int hold_at);
		logic [BAND_W-1:0] b;
		logic [LEVEL_W-1:0] l;
		int pick;
		int near;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			b = $urandom_range(0, 1) ? BAND_W'($urandom_range(0, 7))
				: BAND_W'($urandom_range(0, NUM_BANDS - 1));
			pick = $urandom_range(0, 9);
			if (pick <= 2) begin
				l = LEVEL_W'($urandom_range(0, 300));
			end else if (pick <= 4) begin
				l = LEVEL_W'($urandom_range(0, 15));
			end else if (pick <= 6) begin
				l = LEVEL_W'($urandom_range(0, 1023));
			end else begin
				near = int'(peak_hold[b]) + $urandom_range(0, 40) - 20;
				if (near < 0)
					near = 0;
				if (near > 1023)
					near = 1023;
				l = LEVEL_W'(near);
			end
			offer_band(b, l, 1'($urandom_range(0, 1)), 1'b0, '0);
		end
	endtask

	// Directed rows, decay_step at its reset value of 13. Rows with a typed result
	// produce exactly one pixel that is obvious from the row itself.
	band_req_t dir_plan [21] = '{
		'{7'd0,   10'd0,    1'b0, 1'b1, '{7'd0, 6'd31, 16'hFFFF, 1'b1, 1'b1, 1'b1}}, // fresh peak at 0
		'{7'd127, 10'd7,    1'b1, 1'b1, '{7'd127, 6'd31, 16'hFFFF, 1'b1, 1'b1, 1'b1}},// rise, no bar
		'{7'd127, 10'd0,    1'b1, 1'b1, '{7'd127, 6'd31, 16'hFFFF, 1'b1, 1'b1, 1'b1}},// decay floors at 0
		'{7'd1,   10'd8,    1'b0, 1'b0, '0},  // single bar row
		'{7'd2,   10'd1023, 1'b0, 1'b0, '0},  // clipped bar, peak off panel
		'{7'd2,   10'd0,    1'b0, 1'b1, '{7'd2, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b1}},   // blank
		'{7'd2,   10'd0,    1'b1, 1'b1, '{7'd2, 6'd0, 16'h0000, 1'b0, 1'b0, 1'b1}},   // blank, decays
		'{7'd2,   10'd255,  1'b1, 1'b0, '0},
		'{7'd3,   10'd256,  1'b0, 1'b0, '0},  // exactly full scale
		'{7'd3,   10'd0,    1'b1, 1'b1, '{7'd3, 6'd1, 16'hFFFF, 1'b1, 1'b1, 1'b1}},   // dot near top
		'{7'd4,   10'd255,  1'b0, 1'b0, '0},  // dot on row 0
		'{7'd5,   10'd512,  1'b1, 1'b0, '0},  // rise beats decay
		'{7'd5,   10'd512,  1'b1, 1'b0, '0},  // equal level decays
		'{7'd6,   10'd100,  1'b0, 1'b0, '0},
		'{7'd6,   10'd50,   1'b0, 1'b0, '0},  // peak held above bar
		'{7'd6,   10'd50,   1'b1, 1'b0, '0},
		'{7'd64,  10'd1023, 1'b1, 1'b0, '0},
		'{7'd64,  10'd1023, 1'b0, 1'b0, '0},
		'{7'd85,  10'h2AA,  1'b0, 1'b0, '0},
		'{7'd42,  10'h155,  1'b1, 1'b0, '0},
		'{7'd7,   10'd3,    1'b0, 1'b1, '{7'd7, 6'd31, 16'hFFFF, 1'b1, 1'b1, 1'b1}}
	};

	initial begin : stimulus
		for (int i = 0; i < NUM_BANDS; i++)
			peak_hold[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_plan[i])
			offer_band(dir_plan[i].band, dir_plan[i].lvl, dir_plan[i].decay,
				dir_plan[i].typed, dir_plan[i].want);
		wait_all_pixels();

		// largest step; the output is held off for a long stretch early on
		write_decay_step(8'd255);
		random_bands(70, 10);
		wait_all_pixels();

		// no decay at all
		write_decay_step(8'd0);
		random_bands(70, -1);
		wait_all_pixels();

		write_decay_step(STEP_W'($urandom_range(1, 254)));
		random_bands(70, -1);
		wait_all_pixels();

		// closing stretch at full rate on both sides
		in_idle = 1'b0;
		out_idle = 1'b0;
		write_decay_step(8'd1);
		random_bands(80, -1);
		wait_all_pixels();

		if (pending_pixels.size() != 0) begin
			$display("%0d pixels never arrived", pending_pixels.size());
			errors += pending_pixels.size();
		end
		$display("%0d band requests, %0d pixels checked (%0d peak dots, %0d blank)",
			requests_sent, pixels_seen, dots_seen, blanks_seen);
		$display("%0d decay_step writes incl. 0 and 255, one long output hold, %0d errors",
			cfg_writes, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sbphr_pkg.sv
sv/sbphr_ctrl.sv
sv/sbphr_dp.sv
sv/spectrum_bar_peak_hold_renderer_core.sv
test/spectrum_bar_peak_hold_renderer_core_tb.sv
